// ===== hdl/lsw_pkg.sv =====
// Shared types, constants and width helpers for the LED strip wheel frame driver.
package lsw_pkg;

    localparam int MAX_LEDS_DEF    = 32;
    localparam int BITS_PER_LED    = 24;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_W           = 6;

    localparam logic [CFG_W-1:0] LED_COUNT_RESET = 6'd32;

    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_FILL  = 3'd1;
    localparam logic [2:0] CMD_WHEEL = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    typedef enum logic [1:0] {
        OP_SET,
        OP_FILL,
        OP_START,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  pixel_index;
        logic [23:0] color_word;
        logic [9:0]  level;
    } in_word_t;

    typedef struct packed {
        logic data_bit;
        logic frame_last;
    } out_word_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  idx;
        logic [23:0] color;
    } op_t;

    // Width that holds both the config field and any LED count up to max_leds.
    function automatic int cnt_w(input int max_leds);
        return ($clog2(max_leds + 1) > CFG_W) ? $clog2(max_leds + 1) : CFG_W;
    endfunction

endpackage

// ===== hdl/lsw_ram.sv =====
// Generic single-port-write, registered-read RAM.
module lsw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hdl/lsw_front.sv =====
// Front end: accept command words, compute wheel colors, and classify them into ops.
module lsw_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lsw_pkg::in_word_t s_word,
    output logic              push_valid,
    input  logic              push_ready,
    output lsw_pkg::op_t      push_op
);
    import lsw_pkg::*;

    // floor(level/31) and floor(d*226/93) by reciprocal multiply
    localparam logic [10:0] RECIP_LO = 11'd1058;
    localparam logic [22:0] RECIP_HI = 23'd5096526;

    logic        stage_valid_reg, stage_valid_next;
    logic [2:0]  cmd_reg;
    logic [7:0]  idx_reg;
    logic [23:0] color_reg;
    logic [7:0]  pos_reg, pos_next;

    logic        advance;
    logic        cmd_known;
    logic [20:0] prod_lo;
    logic [9:0]  level_off;
    logic [29:0] prod_hi;

    function automatic logic [23:0] wheel_color(input logic [7:0] pos);
        logic [6:0] r;
        logic [6:0] g;
        logic [6:0] b;
        if (!pos[7]) begin
            r = 7'd127 - pos[6:0];
            g = pos[6:0];
            b = 7'd0;
        end else begin
            r = 7'd0;
            g = 7'd127 - pos[6:0];
            b = pos[6:0];
        end
        return {1'b1, g, 1'b1, r, 1'b1, b};
    endfunction

    always_comb begin
        prod_lo   = 21'(s_word.level) * 21'(RECIP_LO);
        level_off = s_word.level - 10'd931;
        prod_hi   = 30'(level_off[6:0]) * 30'(RECIP_HI);
        if (s_word.level > 10'd930) begin
            pos_next = prod_hi[28:21] + 8'd30;
        end else begin
            pos_next = {2'b00, prod_lo[20:15]};
        end
    end

    always_comb begin
        cmd_known     = 1'b1;
        push_op.kind  = OP_TICK;
        push_op.idx   = idx_reg;
        push_op.color = color_reg;
        case (cmd_reg)
            CMD_SET: begin
                push_op.kind = OP_SET;
            end
            CMD_FILL: begin
                push_op.kind = OP_FILL;
            end
            CMD_WHEEL: begin
                push_op.kind  = OP_FILL;
                push_op.color = wheel_color(pos_reg);
            end
            CMD_START: begin
                push_op.kind = OP_START;
            end
            CMD_TICK: begin
                push_op.kind = OP_TICK;
            end
            default: begin
                cmd_known = 1'b0;
            end
        endcase
    end

    // Drop unknown codes from the stage without a push.
    assign push_valid       = stage_valid_reg && cmd_known;
    assign advance          = !stage_valid_reg || !cmd_known || push_ready;
    assign s_ready          = advance;
    assign stage_valid_next = advance ? s_valid : stage_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        if (advance && s_valid) begin
            cmd_reg   <= s_word.command;
            idx_reg   <= s_word.pixel_index;
            color_reg <= s_word.color_word;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== hdl/lsw_queue.sv =====
// Short op queue between the front end and the back end.
module lsw_queue #(
    parameter int DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  lsw_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop_ready,
    output lsw_pkg::op_t pop_op
);
    import lsw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_op     = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push_fire) begin
            fifo_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hdl/lsw_back.sv =====
// Back end: execute ops on the pixel store and serialize frames one bit per tick.
module lsw_back #(
    parameter int MAX_LEDS = lsw_pkg::MAX_LEDS_DEF,
    parameter int CW       = lsw_pkg::cnt_w(MAX_LEDS),
    parameter int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CW-1:0]      eff_count,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  lsw_pkg::op_t       pop_op,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [23:0]        ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [23:0]        ram_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output lsw_pkg::out_word_t out_word
);
    import lsw_pkg::*;

    localparam int PW  = $clog2(2 * BITS_PER_LED + BITS_PER_LED * MAX_LEDS + 1);
    localparam int LW  = $clog2(MAX_LEDS + 2);
    localparam int BW  = $clog2(BITS_PER_LED);
    localparam int IXW = (CW > 8) ? CW : 8;

    typedef enum logic {
        ST_RUN,
        ST_FILL
    } back_state_t;

    back_state_t     state_reg, state_next;
    logic            frame_active_reg, frame_active_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [LW-1:0]   led_reg, led_next;
    logic [BW-1:0]   bitc_reg, bitc_next;
    logic [CW-1:0]   fill_idx_reg, fill_idx_next;
    logic [23:0]     fill_color_reg, fill_color_next;
    logic [MAX_LEDS-1:0] valid_reg, valid_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_word_reg, m_word_next;

    logic [PW-1:0]   n24;
    logic [PW-1:0]   pix_lo;
    logic            in_pix;
    logic            last_bit;
    logic            out_free;
    logic            pop_fire;
    logic            emit;
    logic            set_wr;
    logic            fill_wr;
    logic [23:0]     px_word;
    logic [BW-1:0]   sh;
    logic            px_bit;

    assign n24    = PW'(eff_count) * PW'(BITS_PER_LED);
    assign pix_lo = PW'(BITS_PER_LED);
    assign in_pix   = (p_reg >= pix_lo) && (p_reg < n24 + pix_lo);
    assign last_bit = (p_reg + PW'(1)) >= (n24 + pix_lo + pix_lo);

    assign out_free  = !m_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_RUN) &&
                       (!frame_active_reg || (pop_op.kind != OP_TICK) || out_free);
    assign pop_fire  = pop_valid && pop_ready;
    assign emit      = pop_fire && frame_active_reg && (pop_op.kind == OP_TICK);

    assign set_wr  = pop_fire && !frame_active_reg && (pop_op.kind == OP_SET) &&
                     (IXW'(pop_op.idx) < IXW'(eff_count));
    assign fill_wr = (state_reg == ST_FILL);

    assign ram_we    = set_wr || fill_wr;
    assign ram_waddr = fill_wr ? fill_idx_reg[AW-1:0] : pop_op.idx[AW-1:0];
    assign ram_wdata = fill_wr ? fill_color_reg : pop_op.color;
    // Read the pixel the counter moves to, so its word is ready on the next tick.
    assign ram_raddr = led_next[AW-1:0];

    assign px_word = valid_reg[led_reg[AW-1:0]] ? ram_rdata : 24'd0;
    assign sh      = BW'(BITS_PER_LED - 1) - bitc_reg;
    assign px_bit  = in_pix ? px_word[sh] : 1'b0;

    always_comb begin
        state_next        = state_reg;
        frame_active_next = frame_active_reg;
        p_next            = p_reg;
        led_next          = led_reg;
        bitc_next         = bitc_reg;
        fill_idx_next     = fill_idx_reg;
        fill_color_next   = fill_color_reg;
        valid_next        = valid_reg;
        m_valid_next      = m_valid_reg && !out_ready;
        m_word_next       = m_word_reg;

        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end

        if (fill_wr) begin
            fill_idx_next = fill_idx_reg + CW'(1);
            if ((fill_idx_reg + CW'(1)) == eff_count) begin
                state_next = ST_RUN;
            end
        end

        if (emit) begin
            m_valid_next         = 1'b1;
            m_word_next.data_bit   = px_bit;
            m_word_next.frame_last = last_bit;
            if (last_bit) begin
                frame_active_next = 1'b0;
                p_next            = '0;
                led_next          = '0;
                bitc_next         = '0;
            end else begin
                p_next = p_reg + PW'(1);
                if (p_reg >= pix_lo) begin
                    if (bitc_reg == BW'(BITS_PER_LED - 1)) begin
                        bitc_next = '0;
                        led_next  = led_reg + LW'(1);
                    end else begin
                        bitc_next = bitc_reg + BW'(1);
                    end
                end
            end
        end else if (pop_fire && !frame_active_reg) begin
            case (pop_op.kind)
                OP_FILL: begin
                    if (eff_count != '0) begin
                        state_next      = ST_FILL;
                        fill_idx_next   = '0;
                        fill_color_next = pop_op.color;
                    end
                end
                OP_START: begin
                    frame_active_next = 1'b1;
                    p_next            = '0;
                    led_next          = '0;
                    bitc_next         = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_RUN;
            frame_active_reg <= 1'b0;
            p_reg            <= '0;
            led_reg          <= '0;
            bitc_reg         <= '0;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            frame_active_reg <= frame_active_next;
            p_reg            <= p_next;
            led_reg          <= led_next;
            bitc_reg         <= bitc_next;
            valid_reg        <= valid_next;
            m_valid_reg      <= m_valid_next;
        end
        fill_idx_reg   <= fill_idx_next;
        fill_color_reg <= fill_color_next;
        m_word_reg     <= m_word_next;
    end

    assign out_valid = m_valid_reg;
    assign out_word  = m_word_reg;

`ifndef ASSERT_OFF
    a_fill_outside_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !frame_active_reg)
        else $error("store fill running during a frame");

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_active_reg |-> (p_reg == '0 && led_reg == '0 && bitc_reg == '0))
        else $error("frame counters not cleared while idle");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bitc_reg <= BW'(BITS_PER_LED - 1))
        else $error("bit counter out of range");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_bit) |=> (!frame_active_reg && m_valid_reg && m_word_reg.frame_last))
        else $error("final bit did not close the frame");
`endif

endmodule

// ===== hdl/led_strip_wheel_frame_driver_core.sv =====
// Top level of the LED strip wheel frame driver: config register, front end, queue, back end.
//
// Usage:
//   s_valid/s_ready/s_word carry command words: set pixel, fill color, fill with a
//   wheel color picked from a 10-bit level, start frame, tick. m_valid/m_ready/m_word
//   return one word per tick of an active frame: the serial data bit and a flag on the
//   frame's final bit. A frame is 24 zeros, each stored pixel MSB first, then 24 zeros.
//   cfg_wr_en/cfg_wr_data write the LED count (clamped to MAX_LEDS); write it only when
//   no command is in flight.
//   Path: a tick passes the input stage, then the queue, and the back end loads the
//   output register that drives m_valid. Throughput: one word per cycle for set pixel,
//   start and tick while m_ready keeps the output register free; a fill holds the back
//   end while it writes each LED's pixel through the single RAM write port. The queue and
//   input stage take up to three more words while a fill walks the store.
//   Reset: the store reads as all zero through per-entry valid flags, so no clearing
//   pass is needed; the frame is idle and the LED count returns to 32.
//   Stall: when m_ready is low the result word holds in the output register, the next
//   tick waits in the queue, and s_ready drops once the queue and input stage fill.
module led_strip_wheel_frame_driver_core #(
    parameter int MAX_LEDS    = lsw_pkg::MAX_LEDS_DEF,
    parameter int QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [lsw_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lsw_pkg::in_word_t         s_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lsw_pkg::out_word_t        m_word
);
    import lsw_pkg::*;

    localparam int CW = cnt_w(MAX_LEDS);
    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    logic [CFG_W-1:0] led_count_reg, led_count_next;
    logic [CW-1:0]    eff_count;

    logic    push_valid;
    logic    push_ready;
    op_t     push_op;
    logic    pop_valid;
    logic    pop_ready;
    op_t     pop_op;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    // Latch the LED count on every write; no handshake.
    assign led_count_next = cfg_wr_en ? cfg_wr_data : led_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= LED_COUNT_RESET;
        end else begin
            led_count_reg <= led_count_next;
        end
    end

    // Clamp the count to what the store holds.
    assign eff_count = (CW'(led_count_reg) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS)
                                                             : CW'(led_count_reg);

    lsw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    lsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    lsw_ram #(
        .WIDTH (BITS_PER_LED),
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lsw_back #(
        .MAX_LEDS (MAX_LEDS),
        .CW       (CW),
        .AW       (AW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_count (eff_count),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the LED strip wheel frame driver core.
`timescale 1ns / 1ps

// Tracks the pixel store and frame state, predicts each tick's serial bit, checks results.
class strip_frame_scoreboard;
    logic [23:0]           leds [lsw_pkg::MAX_LEDS_DEF];
    bit                    frame_on;
    int                    bit_pos;
    int                    led_count;
    int                    mismatches;
    lsw_pkg::out_word_t    expected_bits [$];

    function new();
        foreach (leds[i]) leds[i] = '0;
        frame_on   = 1'b0;
        bit_pos    = 0;
        led_count  = lsw_pkg::LED_COUNT_RESET;
        mismatches = 0;
    endfunction

    // LED count clamped to the store size.
    function int lit_count();
        return (led_count > lsw_pkg::MAX_LEDS_DEF) ? lsw_pkg::MAX_LEDS_DEF : led_count;
    endfunction

    function logic [23:0] wheel_grb(logic [9:0] lvl);
        int         pos;
        logic [7:0] r, g, b;
        if (lvl > 10'd930) begin
            pos = (int'(lvl) - 931) * 226 / 93 + 30;
        end else begin
            pos = int'(lvl) * 30 / 930;
        end
        if (pos < 128) begin
            r = 8'(127 - pos);
            g = 8'(pos);
            b = 8'd0;
        end else begin
            r = 8'd0;
            g = 8'(127 - (pos & 127));
            b = 8'(pos & 127);
        end
        return {g | 8'h80, r | 8'h80, b | 8'h80};
    endfunction

    function void fill_leds(logic [23:0] color);
        for (int i = 0; i < lit_count(); i++) leds[i] = color;
    endfunction

    function void note_command(lsw_pkg::in_word_t w);
        int                 n;
        int                 total;
        int                 q;
        lsw_pkg::out_word_t o;
        if (frame_on) begin
            if (w.command != lsw_pkg::CMD_TICK) return;
            n     = lit_count();
            total = (2 + n) * lsw_pkg::BITS_PER_LED;
            o.data_bit = 1'b0;
            if (bit_pos >= lsw_pkg::BITS_PER_LED &&
                bit_pos - lsw_pkg::BITS_PER_LED < n * lsw_pkg::BITS_PER_LED) begin
                q = bit_pos - lsw_pkg::BITS_PER_LED;
                o.data_bit = leds[q / lsw_pkg::BITS_PER_LED]
                                 [lsw_pkg::BITS_PER_LED - 1 - q % lsw_pkg::BITS_PER_LED];
            end
            o.frame_last = (bit_pos + 1 >= total);
            if (o.frame_last) begin
                frame_on = 1'b0;
                bit_pos  = 0;
            end else begin
                bit_pos++;
            end
            expected_bits.push_back(o);
            return;
        end
        case (w.command)
            lsw_pkg::CMD_SET: begin
                if (w.pixel_index < lit_count()) leds[w.pixel_index] = w.color_word;
            end
            lsw_pkg::CMD_FILL:  fill_leds(w.color_word);
            lsw_pkg::CMD_WHEEL: fill_leds(wheel_grb(w.level));
            lsw_pkg::CMD_START: begin
                frame_on = 1'b1;
                bit_pos  = 0;
            end
            default: ;
        endcase
    endfunction

    function void check_word(lsw_pkg::out_word_t got);
        lsw_pkg::out_word_t want;
        if (expected_bits.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected result word data_bit=%b frame_last=%b",
                         $realtime, got.data_bit, got.frame_last);
            mismatches++;
            return;
        end
        want = expected_bits.pop_front();
        if (got.data_bit !== want.data_bit || got.frame_last !== want.frame_last) begin
            if (mismatches < 10)
                $display("%0t: mismatch data_bit exp %b got %b, frame_last exp %b got %b",
                         $realtime, want.data_bit, got.data_bit,
                         want.frame_last, got.frame_last);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_bits.size();
    endfunction
endclass

module testbench;

    // Unused command codes; the block must ignore them.
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    // Up to four fills can sit in the input stage, queue and back end, each walking
    // the whole store; cover them all plus the pipe.
    localparam int SETTLE_CYCLES = 160;
    // Long receiver hold-off so the queue and input stage back up into s_ready.
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 100;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [lsw_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    lsw_pkg::in_word_t         s_word      = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    lsw_pkg::out_word_t        m_word;

    // Idle and stall rates in percent, changed per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    bit hold_armed     = 1'b0;
    logic m_hold       = 1'b0;

    strip_frame_scoreboard sb;

    always #1 aclk = ~aclk;

    led_strip_wheel_frame_driver_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    // Feed every accepted command word to the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_command(s_word);
    end

    // Check every accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_word);
    end

    // Receiver: stall at the phase rate, and drop ready entirely during the hold-off.
    always @(posedge aclk) begin
        m_ready <= !m_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold off the receiver once, counted here, while the sender keeps offering words.
    initial begin
        wait (hold_armed);
        @(posedge aclk);
        m_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        m_hold <= 1'b0;
    end

    // Safety net: a run that hangs ends here.
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic lsw_pkg::in_word_t make_word(logic [2:0] cmd, logic [7:0] idx,
                                                    logic [23:0] color, logic [9:0] lvl);
        lsw_pkg::in_word_t w;
        w.command     = cmd;
        w.pixel_index = idx;
        w.color_word  = color;
        w.level       = lvl;
        return w;
    endfunction

    function automatic lsw_pkg::in_word_t random_word();
        return make_word(3'($urandom_range(7)), 8'($urandom_range(255)),
                         24'($urandom), 10'($urandom_range(1023)));
    endfunction

    // Favor the wheel's breakpoints, otherwise pick any level.
    function automatic logic [9:0] pick_level();
        case ($urandom_range(7))
            0:       return 10'd0;
            1:       return 10'd930;
            2:       return 10'd931;
            3:       return 10'd1023;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    // Present one word and hold it until accepted; call just after a rising edge.
    task automatic send_word(input lsw_pkg::in_word_t w);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Ticks carry random junk in the unused fields.
    task automatic send_ticks(input int n);
        lsw_pkg::in_word_t w;
        repeat (n) begin
            w = random_word();
            w.command = lsw_pkg::CMD_TICK;
            send_word(w);
        end
    endtask

    // Drop valid, wait for every predicted bit, then let any fill finish.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic change_led_count(input logic [lsw_pkg::CFG_W-1:0] v);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.led_count = v;
    endtask

    // One frame's worth of traffic: a few store updates, start, then ticks.
    task automatic frame_burst();
        int                n;
        int                total;
        int                ticks;
        int                noise_at;
        lsw_pkg::in_word_t w;
        n     = sb.lit_count();
        total = (2 + n) * lsw_pkg::BITS_PER_LED;
        repeat ($urandom_range(3)) begin
            case ($urandom_range(3))
                0: begin
                    // Mostly in range, sometimes any index so out-of-range drops happen.
                    if ($urandom_range(4) == 0 || n == 0)
                        w = make_word(lsw_pkg::CMD_SET, 8'($urandom_range(255)),
                                      24'($urandom), 10'($urandom_range(1023)));
                    else
                        w = make_word(lsw_pkg::CMD_SET, 8'($urandom_range(n - 1)),
                                      24'($urandom), 10'($urandom_range(1023)));
                end
                1: w = make_word(lsw_pkg::CMD_FILL, 8'($urandom_range(255)),
                                 24'($urandom), 10'($urandom_range(1023)));
                default: w = make_word(lsw_pkg::CMD_WHEEL, 8'($urandom_range(255)),
                                       24'($urandom), pick_level());
            endcase
            send_word(w);
        end
        w = random_word();
        w.command = lsw_pkg::CMD_START;
        send_word(w);
        // Long frames are sent in slices; the rest continues in later bursts.
        ticks = (total > 200) ? $urandom_range(40, 160) : total;
        if ($urandom_range(9) == 0) ticks = $urandom_range(1, ticks);
        noise_at = ($urandom_range(9) == 0) ? $urandom_range(ticks - 1) : -1;
        for (int k = 0; k < ticks; k++) begin
            if (k == noise_at) begin
                // Any command but tick must be dropped mid-frame.
                w = random_word();
                if (w.command == lsw_pkg::CMD_TICK) w.command = lsw_pkg::CMD_START;
                send_word(w);
            end
            send_ticks(1);
        end
    endtask

    initial begin
        int phase_counts [8];
        int target;
        phase_counts = '{1, 4, 0, 2, 32, 3, 63, 1};
        sb = new();

        // Hold reset, then release it for good.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: store edges at the reset count of 32, with out-of-range and unused codes.
        send_word(make_word(lsw_pkg::CMD_SET, 8'd0, 24'hFFFFFF, 10'd0));
        send_word(make_word(lsw_pkg::CMD_SET, 8'd31, 24'h800001, 10'd1023));
        send_word(make_word(lsw_pkg::CMD_SET, 8'd32, 24'h123456, 10'd0));
        send_word(make_word(lsw_pkg::CMD_SET, 8'd255, 24'hABCDEF, 10'd1023));
        send_ticks(1);
        send_word(make_word(CMD_RSVD_5, 8'd255, 24'hFFFFFF, 10'd1023));
        send_word(make_word(CMD_RSVD_6, 8'd0, 24'h000000, 10'd0));
        send_word(make_word(CMD_RSVD_7, 8'd1, 24'h5A5A5A, 10'd512));

        // Two LEDs: wheel fill, overwrite one, then a frame with dropped commands inside.
        change_led_count(6'd2);
        send_word(make_word(lsw_pkg::CMD_WHEEL, 8'd0, 24'd0, 10'd0));
        send_word(make_word(lsw_pkg::CMD_SET, 8'd1, 24'hA5A5A5, 10'd0));
        send_word(make_word(lsw_pkg::CMD_START, 8'd0, 24'd0, 10'd0));
        send_word(make_word(lsw_pkg::CMD_START, 8'd0, 24'd0, 10'd0));
        send_word(make_word(lsw_pkg::CMD_FILL, 8'd0, 24'h000000, 10'd0));
        send_ticks(3 * lsw_pkg::BITS_PER_LED + 2 * lsw_pkg::BITS_PER_LED + 1);

        // One LED: wheel breakpoints and a full-white fill, each sent as a frame.
        change_led_count(6'd1);
        foreach (phase_counts[i]) begin
            if (i < 4) begin
                case (i)
                    0: send_word(make_word(lsw_pkg::CMD_WHEEL, 8'd0, 24'd0, 10'd1023));
                    1: send_word(make_word(lsw_pkg::CMD_WHEEL, 8'd0, 24'd0, 10'd930));
                    2: send_word(make_word(lsw_pkg::CMD_WHEEL, 8'd0, 24'd0, 10'd931));
                    default: send_word(make_word(lsw_pkg::CMD_FILL, 8'd0, 24'hFFFFFF, 10'd0));
                endcase
                send_word(make_word(lsw_pkg::CMD_START, 8'd0, 24'd0, 10'd0));
                send_ticks(3 * lsw_pkg::BITS_PER_LED);
            end
        end

        // Shrink the count mid-frame past the new last bit: the next tick ends the frame.
        change_led_count(6'd2);
        send_word(make_word(lsw_pkg::CMD_START, 8'd0, 24'd0, 10'd0));
        send_ticks(80);
        change_led_count(6'd1);
        send_ticks(2);

        // Zero LEDs: writes are dropped and the frame is 48 zero bits.
        change_led_count(6'd0);
        send_word(make_word(lsw_pkg::CMD_SET, 8'd0, 24'h00FF00, 10'd0));
        send_word(make_word(lsw_pkg::CMD_FILL, 8'd0, 24'h000000, 10'd0));
        send_word(make_word(lsw_pkg::CMD_START, 8'd0, 24'd0, 10'd0));
        send_ticks(2 * lsw_pkg::BITS_PER_LED);

        // Random phases: mostly well-formed frames, some noise, idling cycling per phase.
        for (int p = 0; p < 8; p++) begin
            change_led_count(6'(phase_counts[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                // Start the long hold-off once ticks are flowing in the first phase.
                if (p == 0 && !hold_armed && words_sent > target - 60) hold_armed = 1'b1;
                if ($urandom_range(99) < 75) begin
                    frame_burst();
                end else begin
                    repeat ($urandom_range(1, 4)) send_word(random_word());
                end
            end
        end

        drain_pipeline();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
